@@ rtl/core/bhfe_pkg.sv @@
// shared types and constants of the bootloader host frame encoder
`timescale 1ns / 1ps

package bhfe_pkg;

	localparam int MAX_BLOCK = 256;
	localparam int FRAME_MAX = 5;
	localparam int IDX_W = $clog2(FRAME_MAX);

	localparam logic [7:0] BYTE_ONES = 8'hFF;
	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] PAGES_MASS = 8'hFF;

	typedef enum logic [2:0] {
		REQ_COMMAND     = 3'd0,
		REQ_ADDRESS     = 3'd1,
		REQ_WRITE_START = 3'd2,
		REQ_WRITE_DATA  = 3'd3,
		REQ_ERASE_START = 3'd4,
		REQ_ERASE_NEXT  = 3'd5,
		REQ_RESPONSE    = 3'd6,
		REQ_UNUSED      = 3'd7
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NACK   = 2'd1,
		ST_UNEXP  = 2'd2,
		ST_REQERR = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_WRITE = 3'b010,
		PH_ERASE = 3'b100
	} phase_t;

	localparam logic [1:0] CFG_ACK  = 2'd0;
	localparam logic [1:0] CFG_NACK = 2'd1;
	localparam logic [1:0] CFG_EXT  = 2'd2;

	typedef struct packed {
		logic [7:0] ack_code;
		logic [7:0] nack_code;
		logic [7:0] extended_erase_code;
	} cfg_t;

	typedef struct packed {
		req_kind_t   req_type;
		logic [7:0]  code_byte;
		logic [31:0] address;
		logic [8:0]  count;
		logic [7:0]  start_page;
		logic [7:0]  data_byte;
	} item_t;

	// one request's results: a run of bytes, or a single status item
	typedef struct packed {
		logic [FRAME_MAX-1:0][7:0] bytes;
		logic [IDX_W-1:0]          num;
		logic                      has_bytes;
		status_t                   status;
	} frame_t;

endpackage

@@ rtl/core/bhfe_framer.sv @@
// request decoder: builds the frame of one request and keeps the framing state
`timescale 1ns / 1ps

module bhfe_framer
	import bhfe_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  item_t  item,
	input  logic   step,
	output frame_t frame
);

	phase_t     phase_q, phase_d;
	logic [7:0] csum_q, csum_d;
	logic [8:0] bytes_left_q, bytes_left_d;
	logic [7:0] pages_left_q, pages_left_d;
	logic [8:0] next_page_q, next_page_d;
	logic       ext_q, ext_d;

	logic       ext_sel;
	logic [7:0] hdr;
	logic [7:0] addr_x;
	logic [7:0] csum_data;
	logic [8:0] bl_dec;
	logic [7:0] pl_dec;
	logic [7:0] pg_hi;
	logic [7:0] pg_lo;
	logic [7:0] csum_page;
	logic       bad_phase;

	assign ext_sel   = (item.code_byte == cfg.extended_erase_code);
	assign hdr       = item.count[7:0] - 8'd1;
	assign addr_x    = item.address[31:24] ^ item.address[23:16]
	                 ^ item.address[15:8] ^ item.address[7:0];
	assign csum_data = csum_q ^ item.data_byte;
	assign bl_dec    = bytes_left_q - 9'd1;
	assign pl_dec    = pages_left_q - 8'd1;
	assign pg_hi     = ext_q ? {7'd0, next_page_q[8]} : BYTE_ZERO;
	assign pg_lo     = next_page_q[7:0];
	assign csum_page = csum_q ^ pg_hi ^ pg_lo;

	always_comb begin
		unique case (item.req_type)
			REQ_WRITE_DATA: bad_phase = (phase_q != PH_WRITE);
			REQ_ERASE_NEXT: bad_phase = (phase_q != PH_ERASE);
			REQ_RESPONSE:   bad_phase = 1'b0;
			REQ_UNUSED:     bad_phase = 1'b1;
			default:        bad_phase = (phase_q != PH_IDLE);
		endcase
	end

	always_comb begin
		frame        = '0;
		frame.num    = IDX_W'(1);
		frame.status = ST_OK;
		phase_d      = phase_q;
		csum_d       = csum_q;
		bytes_left_d = bytes_left_q;
		pages_left_d = pages_left_q;
		next_page_d  = next_page_q;
		ext_d        = ext_q;
		if (item.req_type == REQ_RESPONSE) begin
			if (item.data_byte == cfg.ack_code) begin
				frame.status = ST_OK;
			end else if (item.data_byte == cfg.nack_code) begin
				frame.status = ST_NACK;
			end else begin
				frame.status = ST_UNEXP;
			end
		end else if (bad_phase) begin
			frame.status = ST_REQERR;
		end else begin
			unique case (item.req_type)
				REQ_COMMAND: begin
					frame.has_bytes = 1'b1;
					frame.num       = IDX_W'(2);
					frame.bytes[0]  = item.code_byte;
					frame.bytes[1]  = item.code_byte ^ BYTE_ONES;
				end
				REQ_ADDRESS: begin
					frame.has_bytes = 1'b1;
					frame.num       = IDX_W'(5);
					frame.bytes[0]  = item.address[31:24];
					frame.bytes[1]  = item.address[23:16];
					frame.bytes[2]  = item.address[15:8];
					frame.bytes[3]  = item.address[7:0];
					frame.bytes[4]  = addr_x;
				end
				REQ_WRITE_START: begin
					if (item.count == '0) begin
						frame.status = ST_OK;
					end else if (item.count > 9'(MAX_BLOCK) || item.address[1:0] != 2'd0
							|| item.count[1:0] != 2'd0) begin
						frame.status = ST_REQERR;
					end else begin
						frame.has_bytes = 1'b1;
						frame.bytes[0]  = hdr;
						csum_d          = hdr;
						bytes_left_d    = item.count;
						phase_d         = PH_WRITE;
					end
				end
				REQ_WRITE_DATA: begin
					frame.has_bytes = 1'b1;
					frame.bytes[0]  = item.data_byte;
					csum_d          = csum_data;
					bytes_left_d    = bl_dec;
					if (bl_dec == '0) begin
						frame.num      = IDX_W'(2);
						frame.bytes[1] = csum_data;
						phase_d        = PH_IDLE;
					end
				end
				REQ_ERASE_START: begin
					if (item.count == '0) begin
						frame.status = ST_OK;
					end else if (item.count[8]) begin
						frame.status = ST_REQERR;
					end else if (item.count[7:0] == PAGES_MASS) begin
						// mass erase
						frame.has_bytes = 1'b1;
						frame.bytes[0]  = BYTE_ONES;
						if (ext_sel) begin
							frame.num      = IDX_W'(3);
							frame.bytes[1] = BYTE_ONES;
							frame.bytes[2] = BYTE_ZERO;
						end else begin
							frame.num      = IDX_W'(2);
							frame.bytes[1] = BYTE_ZERO;
						end
					end else begin
						frame.has_bytes = 1'b1;
						if (ext_sel) begin
							frame.num      = IDX_W'(2);
							frame.bytes[0] = BYTE_ZERO;
							frame.bytes[1] = hdr;
						end else begin
							frame.bytes[0] = hdr;
						end
						csum_d       = hdr;
						pages_left_d = item.count[7:0];
						next_page_d  = {1'b0, item.start_page};
						ext_d        = ext_sel;
						phase_d      = PH_ERASE;
					end
				end
				REQ_ERASE_NEXT: begin
					frame.has_bytes = 1'b1;
					csum_d          = csum_page;
					pages_left_d    = pl_dec;
					if (ext_q) begin
						frame.num      = IDX_W'(2);
						frame.bytes[0] = pg_hi;
						frame.bytes[1] = pg_lo;
						next_page_d    = next_page_q + 9'd1;
						if (pl_dec == '0) begin
							frame.num      = IDX_W'(3);
							frame.bytes[2] = csum_page;
						end
					end else begin
						frame.bytes[0] = pg_lo;
						next_page_d    = {1'b0, pg_lo + 8'd1};
						if (pl_dec == '0) begin
							frame.num      = IDX_W'(2);
							frame.bytes[1] = csum_page;
						end
					end
					if (pl_dec == '0) begin
						phase_d = PH_IDLE;
					end
				end
				default: begin
					frame.status = ST_REQERR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			csum_q       <= '0;
			bytes_left_q <= '0;
			pages_left_q <= '0;
			next_page_q  <= '0;
			ext_q        <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			csum_q       <= csum_d;
			bytes_left_q <= bytes_left_d;
			pages_left_q <= pages_left_d;
			next_page_q  <= next_page_d;
			ext_q        <= ext_d;
		end
	end

endmodule

@@ rtl/core/bhfe_serializer.sv @@
// frame register: holds one frame and hands out its items one per cycle while out_ready is high
`timescale 1ns / 1ps

module bhfe_serializer
	import bhfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  frame_t     frame,
	input  logic       load,
	output logic       load_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output status_t    status,
	output logic       last
);

	frame_t           frame_s2;
	logic [IDX_W-1:0] idx_q;
	logic             busy_q;

	assign out_valid  = busy_q;
	assign out_byte   = frame_s2.bytes[idx_q];
	assign byte_valid = frame_s2.has_bytes;
	assign status     = frame_s2.status;
	assign last       = (idx_q == frame_s2.num - IDX_W'(1));
	assign load_ready = !busy_q || (out_ready && last);

	always_ff @(posedge clk) begin
		if (load) begin
			frame_s2 <= frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && out_ready) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

endmodule

@@ rtl/core/bootloader_host_frame_encoder.sv @@
// top level of the bootloader host frame encoder
// an accepted item goes through the input register and then the frame register, from which its results come out
// output: one result per cycle while m_axis_tready is high; a request has 1 to 5 results,
// all sent one after another through the single output byte port
// requests follow back to back, the next one is taken while a frame drains
// reset: arst_n clears the framing state to idle and the code registers to 0x79, 0x1F, 0x44
`timescale 1ns / 1ps

module bootloader_host_frame_encoder
	import bhfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// request items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// code_byte[7:0], address[39:8], count[48:40], start_page[56:49], data_byte[64:57]
	input  logic [71:0] s_axis_tdata,
	// req_type[2:0]
	input  logic [2:0]  s_axis_tuser,
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_byte[7:0], status[9:8]
	output logic [15:0] m_axis_tdata,
	// byte_valid[0]
	output logic        m_axis_tuser,
	output logic        m_axis_tlast,
	// code register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	// input register
	item_t item_s1;
	logic  valid_s1;

	cfg_t   cfg_q;
	frame_t frame;
	logic   load_ready;
	logic   advance;

	logic [7:0] out_byte;
	status_t    status;

	// the request moves on once the frame register is free or drains this cycle
	assign advance       = valid_s1 && load_ready;
	assign s_axis_tready = !valid_s1 || load_ready;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.req_type   <= req_kind_t'(s_axis_tuser);
			item_s1.code_byte  <= s_axis_tdata[7:0];
			item_s1.address    <= s_axis_tdata[39:8];
			item_s1.count      <= s_axis_tdata[48:40];
			item_s1.start_page <= s_axis_tdata[56:49];
			item_s1.data_byte  <= s_axis_tdata[64:57];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// code registers; the user must write them only while no request is in flight, the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ack_code            <= 8'h79;
			cfg_q.nack_code           <= 8'h1F;
			cfg_q.extended_erase_code <= 8'h44;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ACK:  cfg_q.ack_code            <= cfg_data;
				CFG_NACK: cfg_q.nack_code           <= cfg_data;
				CFG_EXT:  cfg_q.extended_erase_code <= cfg_data;
				default:  ;
			endcase
		end
	end

	// decode and state update happen when the request moves into the frame register
	bhfe_framer u_framer (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item_s1),
		.step   (advance),
		.frame  (frame)
	);

	bhfe_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame      (frame),
		.load       (advance),
		.load_ready (load_ready),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (out_byte),
		.byte_valid (m_axis_tuser),
		.status     (status),
		.last       (m_axis_tlast)
	);

	assign m_axis_tdata = {6'd0, status, out_byte};

endmodule

@@ bench/tb.sv @@
// testbench of the bootloader host frame encoder: directed table, then random request streams
`timescale 1ns / 1ps

module tb;
	import bhfe_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int PRINT_LIMIT   = 40;

	// one result item as the encoder should deliver it
	typedef struct {
		logic [7:0] out_byte;
		logic       byte_valid;
		status_t    status;
		logic       last;
	} frame_result_t;

	// one row of the directed table; typed rows carry their single status result
	typedef struct {
		req_kind_t   kind;
		logic [7:0]  code;
		logic [31:0] addr;
		logic [8:0]  count;
		logic [7:0]  spage;
		logic [7:0]  data;
		bit          typed;
		status_t     st;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	// pacing of both sides, in percent of cycles
	int send_idle_pct;
	int recv_stall_pct = 0;
	logic hold_on;
	event start_hold;

	// expected results in arrival order, and the frame of the request just predicted
	frame_result_t tx_expected[$];
	frame_result_t frame_buf[$];

	// predictor copy of the code registers and the framing state
	logic [7:0] ack_byte;
	logic [7:0] nack_byte;
	logic [7:0] ext_erase_code;
	phase_t     fr_phase;
	logic [7:0] fr_sum;
	logic [8:0] fr_bytes_left;
	logic [7:0] fr_pages_left;
	logic [8:0] fr_page;
	logic       fr_ext;

	int items_sent;
	int results_seen;
	int mismatches;
	int cycles;

	dir_row_t directed_rows [27];

	bootloader_host_frame_encoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// run guard: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycles,
				tx_expected.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < PRINT_LIMIT)
			$display("mismatch at result %0d: %s got %0h expected %0h", results_seen, what,
				got, want);
		mismatches++;
	endtask

	function automatic void emit(input logic [7:0] b, input logic v, input status_t st);
		frame_result_t r;
		r.out_byte = b;
		r.byte_valid = v;
		r.status = st;
		r.last = 1'b0;
		frame_buf.push_back(r);
	endfunction

	// works out the result items of one request and advances the framing state
	function automatic void predict_frame(input item_t it);
		logic [7:0] hi;
		logic [7:0] lo;
		logic [7:0] hdr;
		logic       ext;
		frame_buf.delete();
		if (it.req_type == REQ_RESPONSE) begin
			// ack check wins when both codes are equal
			if (it.data_byte == ack_byte)
				emit(8'h00, 1'b0, ST_OK);
			else if (it.data_byte == nack_byte)
				emit(8'h00, 1'b0, ST_NACK);
			else
				emit(8'h00, 1'b0, ST_UNEXP);
		end else if (it.req_type == REQ_UNUSED
				|| (it.req_type == REQ_WRITE_DATA && fr_phase != PH_WRITE)
				|| (it.req_type == REQ_ERASE_NEXT && fr_phase != PH_ERASE)
				|| (it.req_type != REQ_WRITE_DATA && it.req_type != REQ_ERASE_NEXT
					&& fr_phase != PH_IDLE)) begin
			// out of order: refused, state untouched
			emit(8'h00, 1'b0, ST_REQERR);
		end else begin
			case (it.req_type)
				REQ_COMMAND: begin
					emit(it.code_byte, 1'b1, ST_OK);
					emit(it.code_byte ^ BYTE_ONES, 1'b1, ST_OK);
				end
				REQ_ADDRESS: begin
					emit(it.address[31:24], 1'b1, ST_OK);
					emit(it.address[23:16], 1'b1, ST_OK);
					emit(it.address[15:8], 1'b1, ST_OK);
					emit(it.address[7:0], 1'b1, ST_OK);
					emit(it.address[31:24] ^ it.address[23:16] ^ it.address[15:8]
						^ it.address[7:0], 1'b1, ST_OK);
				end
				REQ_WRITE_START: begin
					if (it.count == 9'd0)
						emit(8'h00, 1'b0, ST_OK);
					else if (it.count > MAX_BLOCK || it.address[1:0] != 2'b00
							|| it.count[1:0] != 2'b00)
						emit(8'h00, 1'b0, ST_REQERR);
					else begin
						fr_sum = 8'(it.count - 9'd1);
						fr_bytes_left = it.count;
						fr_phase = PH_WRITE;
						emit(fr_sum, 1'b1, ST_OK);
					end
				end
				REQ_WRITE_DATA: begin
					emit(it.data_byte, 1'b1, ST_OK);
					fr_sum = fr_sum ^ it.data_byte;
					fr_bytes_left = fr_bytes_left - 9'd1;
					if (fr_bytes_left == 9'd0) begin
						emit(fr_sum, 1'b1, ST_OK);
						fr_phase = PH_IDLE;
					end
				end
				REQ_ERASE_START: begin
					ext = (it.code_byte == ext_erase_code);
					if (it.count == 9'd0)
						emit(8'h00, 1'b0, ST_OK);
					else if (it.count > 9'd255)
						emit(8'h00, 1'b0, ST_REQERR);
					else if (it.count == 9'd255) begin
						// mass erase header, no page list follows
						emit(BYTE_ONES, 1'b1, ST_OK);
						if (ext)
							emit(BYTE_ONES, 1'b1, ST_OK);
						emit(BYTE_ZERO, 1'b1, ST_OK);
					end else begin
						hdr = 8'(it.count - 9'd1);
						if (ext)
							emit(BYTE_ZERO, 1'b1, ST_OK);
						emit(hdr, 1'b1, ST_OK);
						fr_sum = hdr;
						fr_pages_left = it.count[7:0];
						fr_page = {1'b0, it.start_page};
						fr_ext = ext;
						fr_phase = PH_ERASE;
					end
				end
				default: begin
					if (fr_ext) begin
						// two-byte page numbers run past 255 without wrapping
						hi = {7'd0, fr_page[8]};
						lo = fr_page[7:0];
						emit(hi, 1'b1, ST_OK);
						emit(lo, 1'b1, ST_OK);
						fr_sum = fr_sum ^ hi ^ lo;
						fr_page = fr_page + 9'd1;
					end else begin
						// one-byte page numbers wrap at 256
						lo = fr_page[7:0];
						emit(lo, 1'b1, ST_OK);
						fr_sum = fr_sum ^ lo;
						fr_page = {1'b0, lo + 8'd1};
					end
					fr_pages_left = fr_pages_left - 8'd1;
					if (fr_pages_left == 8'd0) begin
						emit(fr_sum, 1'b1, ST_OK);
						fr_phase = PH_IDLE;
					end
				end
			endcase
		end
		frame_buf[frame_buf.size() - 1].last = 1'b1;
	endfunction

	// fully random request, count mostly small so stray erase lists stay short
	function automatic item_t random_request();
		item_t it;
		it.req_type = req_kind_t'($urandom_range(7));
		it.code_byte = 8'($urandom_range(255));
		it.address = $urandom;
		it.count = ($urandom_range(9) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(8));
		it.start_page = 8'($urandom_range(255));
		it.data_byte = 8'($urandom_range(255));
		return it;
	endfunction

	// offers one request item, waits for its handshake, then books its expected results
	task automatic offer(input item_t it, input bit typed, input status_t typed_st);
		frame_result_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.req_type;
		s_axis_tdata <= {7'd0, it.data_byte, it.start_page, it.count, it.address, it.code_byte};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		predict_frame(it);
		if (typed) begin
			r.out_byte = 8'h00;
			r.byte_valid = 1'b0;
			r.status = typed_st;
			r.last = 1'b1;
			tx_expected.push_back(r);
		end else begin
			foreach (frame_buf[k])
				tx_expected.push_back(frame_buf[k]);
		end
	endtask

	// sender stops and waits until every booked result has come out
	task automatic await_results();
		s_axis_tvalid <= 1'b0;
		while (tx_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_codes(input logic [7:0] ack_v, input logic [7:0] nack_v,
			input logic [7:0] ext_v);
		logic [1:0] regs [3];
		logic [7:0] vals [3];
		regs = '{CFG_ACK, CFG_NACK, CFG_EXT};
		vals = '{ack_v, nack_v, ext_v};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		ack_byte = ack_v;
		nack_byte = nack_v;
		ext_erase_code = ext_v;
	endtask

	// write block: start, data bytes until the checksum, with stray requests mixed in
	task automatic write_block(input int n, input logic [31:0] addr);
		item_t it;
		it = random_request();
		it.req_type = REQ_WRITE_START;
		it.address = addr;
		it.count = n[8:0];
		offer(it, 1'b0, ST_OK);
		while (fr_phase == PH_WRITE) begin
			it = random_request();
			if ($urandom_range(99) >= 8)
				it.req_type = REQ_WRITE_DATA;
			offer(it, 1'b0, ST_OK);
		end
	endtask

	// erase list: start, one next per page until the checksum, with stray requests mixed in
	task automatic erase_list(input bit ext, input int n, input logic [7:0] first_page);
		item_t it;
		it = random_request();
		it.req_type = REQ_ERASE_START;
		it.code_byte = ext ? ext_erase_code : 8'($urandom_range(255));
		if (!ext && it.code_byte == ext_erase_code)
			it.code_byte = ~ext_erase_code;
		it.count = n[8:0];
		it.start_page = first_page;
		offer(it, 1'b0, ST_OK);
		while (fr_phase == PH_ERASE) begin
			it = random_request();
			if ($urandom_range(99) >= 8)
				it.req_type = REQ_ERASE_NEXT;
			offer(it, 1'b0, ST_OK);
		end
	endtask

	task automatic random_sequence();
		item_t it;
		int pick;
		int r;
		it = random_request();
		// close any frame that stray traffic has opened
		while (fr_phase != PH_IDLE) begin
			it.req_type = (fr_phase == PH_WRITE) ? REQ_WRITE_DATA : REQ_ERASE_NEXT;
			offer(it, 1'b0, ST_OK);
			it = random_request();
		end
		pick = $urandom_range(99);
		if (pick < 15) begin
			it.req_type = REQ_COMMAND;
			offer(it, 1'b0, ST_OK);
		end else if (pick < 27) begin
			it.req_type = REQ_ADDRESS;
			offer(it, 1'b0, ST_OK);
		end else if (pick < 50) begin
			write_block(4 * $urandom_range(1, 4), {it.address[31:2], 2'b00});
		end else if (pick < 72) begin
			r = $urandom_range(9);
			erase_list($urandom_range(1), (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(1, 6),
				it.start_page);
		end else if (pick < 85) begin
			r = $urandom_range(2);
			it.req_type = REQ_RESPONSE;
			if (r == 0)
				it.data_byte = ack_byte;
			else if (r == 1)
				it.data_byte = nack_byte;
			offer(it, 1'b0, ST_OK);
		end else begin
			offer(it, 1'b0, ST_OK);
		end
	endtask

	task automatic random_phase(input int n);
		int first;
		first = items_sent;
		while (items_sent - first < n)
			random_sequence();
	endtask

	// long output stall, timed on its own so the sender keeps pushing meanwhile
	initial begin
		hold_on = 1'b0;
		forever begin
			@(start_hold);
			hold_on <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	// result side: random stalls, every accepted item checked against the oldest expectation
	always @(posedge clk) begin : result_monitor
		frame_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (tx_expected.size() == 0) begin
				report_mismatch("item with nothing pending, byte", m_axis_tdata[7:0], 0);
			end else begin
				want = tx_expected.pop_front();
				if (m_axis_tdata[7:0] !== want.out_byte)
					report_mismatch("out_byte", m_axis_tdata[7:0], want.out_byte);
				if (m_axis_tuser !== want.byte_valid)
					report_mismatch("byte_valid", m_axis_tuser, want.byte_valid);
				if (m_axis_tdata[9:8] !== want.status)
					report_mismatch("status", m_axis_tdata[9:8], want.status);
				if (m_axis_tlast !== want.last)
					report_mismatch("last", m_axis_tlast, want.last);
			end
			results_seen++;
		end
		m_axis_tready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		item_t it;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = REQ_COMMAND;
		cfg_valid = 1'b0;
		cfg_index = CFG_ACK;
		cfg_data = 8'h00;
		send_idle_pct = 0;
		items_sent = 0;
		results_seen = 0;
		mismatches = 0;
		cycles = 0;

		// predictor starts from the reset values
		ack_byte = 8'h79;
		nack_byte = 8'h1F;
		ext_erase_code = 8'h44;
		fr_phase = PH_IDLE;
		fr_sum = 8'h00;
		fr_bytes_left = 9'd0;
		fr_pages_left = 8'd0;
		fr_page = 9'd0;
		fr_ext = 1'b0;

		// directed table: reset codes, refusals, frame extremes, page wrap in one-byte mode, pages past 255 in two-byte mode
		directed_rows = '{
			'{REQ_RESPONSE,    8'h00, 32'h0000_0000, 9'd0,   8'h00, 8'h79, 1'b1, ST_OK},
			'{REQ_RESPONSE,    8'h00, 32'h0000_0000, 9'd0,   8'h00, 8'h1F, 1'b1, ST_NACK},
			'{REQ_RESPONSE,    8'h00, 32'h0000_0000, 9'd0,   8'h00, 8'h00, 1'b1, ST_UNEXP},
			'{REQ_UNUSED,      8'h00, 32'h0000_0000, 9'd0,   8'h00, 8'h00, 1'b1, ST_REQERR},
			'{REQ_WRITE_DATA,  8'h00, 32'h0000_0000, 9'd0,   8'h00, 8'hAA, 1'b1, ST_REQERR},
			'{REQ_ERASE_NEXT,  8'h00, 32'h0000_0000, 9'd0,   8'h00, 8'h00, 1'b1, ST_REQERR},
			'{REQ_COMMAND,     8'h00, 32'h0000_0000, 9'd0,   8'h00, 8'h00, 1'b0, ST_OK},
			'{REQ_COMMAND,     8'hFF, 32'h0000_0000, 9'd0,   8'h00, 8'h00, 1'b0, ST_OK},
			'{REQ_ADDRESS,     8'h00, 32'hFFFF_FFFF, 9'd0,   8'h00, 8'h00, 1'b0, ST_OK},
			'{REQ_WRITE_START, 8'h00, 32'h0800_0000, 9'd0,   8'h00, 8'h00, 1'b1, ST_OK},
			'{REQ_WRITE_START, 8'h00, 32'h0800_0000, 9'd260, 8'h00, 8'h00, 1'b1, ST_REQERR},
			'{REQ_WRITE_START, 8'h00, 32'h0800_0001, 9'd4,   8'h00, 8'h00, 1'b1, ST_REQERR},
			'{REQ_WRITE_START, 8'h00, 32'hFFFF_FFFC, 9'd4,   8'h00, 8'h00, 1'b0, ST_OK},
			'{REQ_WRITE_DATA,  8'h00, 32'h0000_0000, 9'd0,   8'h00, 8'h00, 1'b0, ST_OK},
			'{REQ_WRITE_DATA,  8'h00, 32'h0000_0000, 9'd0,   8'h00, 8'hFF, 1'b0, ST_OK},
			'{REQ_WRITE_DATA,  8'h00, 32'h0000_0000, 9'd0,   8'h00, 8'hA5, 1'b0, ST_OK},
			'{REQ_WRITE_DATA,  8'h00, 32'h0000_0000, 9'd0,   8'h00, 8'h3C, 1'b0, ST_OK},
			'{REQ_ERASE_START, 8'h00, 32'h0000_0000, 9'd0,   8'h00, 8'h00, 1'b1, ST_OK},
			'{REQ_ERASE_START, 8'h00, 32'h0000_0000, 9'd256, 8'h00, 8'h00, 1'b1, ST_REQERR},
			'{REQ_ERASE_START, 8'h00, 32'h0000_0000, 9'd255, 8'h00, 8'h00, 1'b0, ST_OK},
			'{REQ_ERASE_START, 8'h44, 32'h0000_0000, 9'd255, 8'h00, 8'h00, 1'b0, ST_OK},
			'{REQ_ERASE_START, 8'h12, 32'h0000_0000, 9'd2,   8'hFF, 8'h00, 1'b0, ST_OK},
			'{REQ_ERASE_NEXT,  8'h00, 32'h0000_0000, 9'd0,   8'h00, 8'h00, 1'b0, ST_OK},
			'{REQ_ERASE_NEXT,  8'h00, 32'h0000_0000, 9'd0,   8'h00, 8'h00, 1'b0, ST_OK},
			'{REQ_ERASE_START, 8'h44, 32'h0000_0000, 9'd2,   8'hFF, 8'h00, 1'b0, ST_OK},
			'{REQ_ERASE_NEXT,  8'h00, 32'h0000_0000, 9'd0,   8'h00, 8'h00, 1'b0, ST_OK},
			'{REQ_ERASE_NEXT,  8'h00, 32'h0000_0000, 9'd0,   8'h00, 8'h00, 1'b0, ST_OK}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			it.req_type = directed_rows[i].kind;
			it.code_byte = directed_rows[i].code;
			it.address = directed_rows[i].addr;
			it.count = directed_rows[i].count;
			it.start_page = directed_rows[i].spage;
			it.data_byte = directed_rows[i].data;
			offer(it, directed_rows[i].typed, directed_rows[i].st);
		end
		await_results();

		// code extremes, sender idling
		write_codes(8'h00, 8'hFF, 8'h00);
		send_idle_pct = 54;
		random_phase(30);
		await_results();

		// opposite extremes, receiver stalling
		write_codes(8'hFF, 8'h00, 8'hFF);
		send_idle_pct = 0;
		recv_stall_pct <= 54;
		random_phase(30);
		await_results();

		// ack and nack equal so ack must win, both sides idling
		write_codes(8'h5A, 8'h5A, 8'($urandom_range(255)));
		send_idle_pct = 32;
		recv_stall_pct <= 32;
		random_phase(30);
		await_results();

		// back to reset codes; output held off while the sender keeps going, input backs up
		write_codes(8'h79, 8'h1F, 8'h44);
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		-> start_hold;
		random_phase(30);
		await_results();

		// a longer block and an extended list whose page numbers cross 255
		send_idle_pct = 32;
		recv_stall_pct <= 32;
		write_block(16, {$urandom_range(32'h3FFF_FFFF), 2'b00});
		erase_list(1'b1, 4, 8'hFE);
		await_results();

		$display("requests sent %0d, result items checked %0d, mismatches %0d", items_sent,
			results_seen, mismatches);
		$display("covered all request kinds, four code settings, stalls on both sides and"
			, " extended page numbers past 255");
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
